// ===== rtl/vfcam_pkg.sv =====
// Shared types, constants and corner tables for the voxel face mesher.
`default_nettype none

package vfcam_pkg;

    localparam int CHUNK_EDGE  = 32;
    localparam int COORD_W     = 5;
    localparam int VCOORD_W    = 6;
    localparam int TILE_W      = 8;
    localparam int REG_W       = 17;
    localparam int UV_W        = 25;
    localparam int CNT_W       = 20;
    localparam int NB_W        = 27;
    localparam int FACES       = 6;
    localparam int CORNERS     = 4;
    localparam int FACE_W      = 3;
    localparam int CORNER_W    = 2;
    localparam int AO_W        = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [REG_W-1:0]    TILE_RESET  = 17'h10000;
    localparam logic                REG_TILE_WIDTH  = 1'b0;
    localparam logic                REG_TILE_HEIGHT = 1'b1;
    localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;
    localparam logic [AO_W-1:0]     AO_MAX      = 2'd3;

    // Corner offsets, bit 0 = x, bit 1 = y, bit 2 = z.
    localparam logic [2:0] CORNER_TAB [FACES][CORNERS] = '{
        '{3'b011, 3'b111, 3'b101, 3'b001},
        '{3'b110, 3'b010, 3'b000, 3'b100},
        '{3'b110, 3'b111, 3'b011, 3'b010},
        '{3'b000, 3'b001, 3'b101, 3'b100},
        '{3'b110, 3'b100, 3'b101, 3'b111},
        '{3'b011, 3'b001, 3'b000, 3'b010}
    };

    // Local UV, bit 0 = u, bit 1 = v.
    localparam logic [1:0] UV_TAB [FACES][CORNERS] = '{
        '{2'b00, 2'b01, 2'b11, 2'b10},
        '{2'b00, 2'b01, 2'b11, 2'b10},
        '{2'b00, 2'b01, 2'b11, 2'b10},
        '{2'b00, 2'b01, 2'b11, 2'b10},
        '{2'b00, 2'b10, 2'b11, 2'b01},
        '{2'b00, 2'b10, 2'b11, 2'b01}
    };

    typedef struct packed {
        logic                                    new_chunk;
        logic [FACES-1:0]                        face_mask;
        logic [FACES-1:0]                        flip;
        logic [FACES-1:0][CORNERS-1:0][AO_W-1:0] ao;
        logic [COORD_W-1:0]                      bx;
        logic [COORD_W-1:0]                      by;
        logic [COORD_W-1:0]                      bz;
        logic [TILE_W-1:0]                       tcol;
        logic [TILE_W-1:0]                       trow;
    } job_t;

    function automatic int nb_index(input int dx, input int dy, input int dz);
        return (dz + 1) * 9 + (dy + 1) * 3 + (dx + 1);
    endfunction

    function automatic int normal_index(input int f);
        int d [3];
        int a;
        for (a = 0; a < 3; a++) begin
            d[a] = 0;
        end
        d[f >> 1] = ((f & 1) != 0) ? -1 : 1;
        return nb_index(d[0], d[1], d[2]);
    endfunction

    function automatic logic [AO_W-1:0] corner_ao(input logic [NB_W-1:0] nb,
                                                  input int f, input int c);
        int n;
        int t0;
        int t1;
        int a;
        int d1 [3];
        int d2 [3];
        int d3 [3];
        logic [2:0] co;
        logic s1;
        logic s2;
        logic cc;
        logic [AO_W-1:0] sum;
        n  = f >> 1;
        t0 = (n == 0) ? 1 : 0;
        t1 = (n == 2) ? 1 : 2;
        co = CORNER_TAB[f][c];
        for (a = 0; a < 3; a++) begin
            d1[a] = (a == n) ? (((f & 1) != 0) ? -1 : 1) : 0;
            d2[a] = d1[a];
            d3[a] = d1[a];
        end
        d1[t0] = d1[t0] + (co[t0] ? 1 : -1);
        d2[t1] = d2[t1] + (co[t1] ? 1 : -1);
        d3[t0] = d3[t0] + (co[t0] ? 1 : -1);
        d3[t1] = d3[t1] + (co[t1] ? 1 : -1);
        s1  = nb[nb_index(d1[0], d1[1], d1[2])];
        s2  = nb[nb_index(d2[0], d2[1], d2[2])];
        cc  = nb[nb_index(d3[0], d3[1], d3[2])];
        sum = {1'b0, s1} + {1'b0, s2} + {1'b0, cc};
        if (s1 && s2) begin
            return '0;
        end
        return AO_MAX - sum;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/voxel_face_cull_ao_mesher.sv =====
// Top level of the voxel face mesher: register port, front end, job queue, back end.
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | one block, tuser = new_chunk
//  m_axis   | out       | m_axis_tvalid/tready    | one vertex, tlast = last vertex
//  apb      | in        | psel/penable/pready     | tile_width_q16 @0, tile_height_q16 @4
//
// One vertex beat per cycle while m_axis_tready allows: a block with k kept faces gives 4*k beats.
// A block with no kept face but new_chunk set only restarts numbering; others are dropped.
// After the block beat, a first vertex passes queue, job register and output register.
// Synchronous reset: vertex count 0, queue empty, both tile registers 1.0 in Q16.
// m_axis_tready low holds the output register; s_axis_tready falls when four jobs wait.
`default_nettype none

module voxel_face_cull_ao_mesher (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // x[4:0] y[9:5] z[14:10] opaque[15] neighbour[42:16] col[50:43] row[58:51]
    input  wire logic [63:0]                   s_axis_tdata,
    // new_chunk[0]
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // number[19:0] x[25:20] y[31:26] z[37:32] u[62:38] v[87:63]
    // face[90:88] occlusion[92:91] flip[93]
    output logic [95:0]                        m_axis_tdata,
    output logic                               m_axis_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vfcam_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [vfcam_pkg::DATA_W-1:0]  pwdata,
    output logic [vfcam_pkg::DATA_W-1:0]       prdata,
    output logic                               pready
);
    import vfcam_pkg::*;

    logic [REG_W-1:0]    tile_width_reg;
    logic [REG_W-1:0]    tile_width_next;
    logic [REG_W-1:0]    tile_height_reg;
    logic [REG_W-1:0]    tile_height_next;
    logic                cfg_write;

    logic                q_full;
    logic                push;
    job_t                push_job;
    logic                pop;
    logic                head_valid;
    job_t                head_job;

    logic [CNT_W-1:0]    vertex_number;
    logic [VCOORD_W-1:0] vert_x;
    logic [VCOORD_W-1:0] vert_y;
    logic [VCOORD_W-1:0] vert_z;
    logic [UV_W-1:0]     tex_u;
    logic [UV_W-1:0]     tex_v;
    logic [FACE_W-1:0]   face_number;
    logic [AO_W-1:0]     occlusion;
    logic                flip_diagonal;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        tile_width_next  = tile_width_reg;
        tile_height_next = tile_height_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_TILE_WIDTH:  tile_width_next  = pwdata[REG_W-1:0];
                REG_TILE_HEIGHT: tile_height_next = pwdata[REG_W-1:0];
                default: ;
            endcase
        end
        case (paddr[2])
            REG_TILE_WIDTH:  prdata = DATA_W'(tile_width_reg);
            REG_TILE_HEIGHT: prdata = DATA_W'(tile_height_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_width_reg  <= TILE_RESET;
            tile_height_reg <= TILE_RESET;
        end else begin
            tile_width_reg  <= tile_width_next;
            tile_height_reg <= tile_height_next;
        end
    end

    vfcam_front u_front (
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .new_chunk        (s_axis_tuser),
        .block_x          (s_axis_tdata[4:0]),
        .block_y          (s_axis_tdata[9:5]),
        .block_z          (s_axis_tdata[14:10]),
        .block_opaque     (s_axis_tdata[15]),
        .neighbour_opaque (s_axis_tdata[42:16]),
        .tile_col         (s_axis_tdata[50:43]),
        .tile_row         (s_axis_tdata[58:51]),
        .q_full           (q_full),
        .push             (push),
        .push_job         (push_job)
    );

    vfcam_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    vfcam_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_job        (head_job),
        .pop             (pop),
        .tile_width_q16  (tile_width_reg),
        .tile_height_q16 (tile_height_reg),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .vertex_number   (vertex_number),
        .vert_x          (vert_x),
        .vert_y          (vert_y),
        .vert_z          (vert_z),
        .tex_u           (tex_u),
        .tex_v           (tex_v),
        .face_number     (face_number),
        .occlusion       (occlusion),
        .flip_diagonal   (flip_diagonal),
        .last_vertex     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, flip_diagonal, occlusion, face_number, tex_v, tex_u,
                           vert_z, vert_y, vert_x, vertex_number};

endmodule

`default_nettype wire

// ===== rtl/vfcam_front.sv =====
// Front end: accept block beats, cull faces, work out occlusion and quad flip.
`default_nettype none

module vfcam_front (
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic                         new_chunk,
    input  wire logic [vfcam_pkg::COORD_W-1:0] block_x,
    input  wire logic [vfcam_pkg::COORD_W-1:0] block_y,
    input  wire logic [vfcam_pkg::COORD_W-1:0] block_z,
    input  wire logic                         block_opaque,
    input  wire logic [vfcam_pkg::NB_W-1:0]    neighbour_opaque,
    input  wire logic [vfcam_pkg::TILE_W-1:0]  tile_col,
    input  wire logic [vfcam_pkg::TILE_W-1:0]  tile_row,
    input  wire logic                         q_full,
    output logic                              push,
    output vfcam_pkg::job_t                   push_job
);
    import vfcam_pkg::*;

    logic in_range;
    logic [2:0] diag02;
    logic [2:0] diag13;

    always_comb begin
        diag02 = '0;
        diag13 = '0;
        in_range = (int'(block_x) < CHUNK_EDGE) && (int'(block_y) < CHUNK_EDGE) &&
                   (int'(block_z) < CHUNK_EDGE);
        push_job.new_chunk = new_chunk;
        push_job.bx   = block_x;
        push_job.by   = block_y;
        push_job.bz   = block_z;
        push_job.tcol = tile_col;
        push_job.trow = tile_row;
        for (int f = 0; f < FACES; f++) begin
            push_job.face_mask[f] = block_opaque && in_range &&
                                    !neighbour_opaque[normal_index(f)];
            for (int c = 0; c < CORNERS; c++) begin
                push_job.ao[f][c] = corner_ao(neighbour_opaque, f, c);
            end
            diag02 = {1'b0, push_job.ao[f][0]} + {1'b0, push_job.ao[f][2]};
            diag13 = {1'b0, push_job.ao[f][1]} + {1'b0, push_job.ao[f][3]};
            push_job.flip[f] = diag02 < diag13;
        end
    end

    // Drop beats that give no vertex and do not restart numbering.
    assign s_axis_tready = !q_full;
    assign push = s_axis_tvalid && !q_full && ((|push_job.face_mask) || new_chunk);

endmodule

`default_nettype wire

// ===== rtl/vfcam_queue.sv =====
// Short job queue between the cull front end and the vertex back end.
`default_nettype none

module vfcam_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire vfcam_pkg::job_t push_job,
    input  wire logic            pop,
    output logic                 full,
    output logic                 head_valid,
    output vfcam_pkg::job_t      head_job
);
    import vfcam_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_pop;

    assign full       = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (do_pop && !push) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/vfcam_back.sv =====
// Back end: walk kept faces and corners, one vertex beat per unstalled cycle, with UV multiply.
`default_nettype none

module vfcam_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          head_valid,
    input  wire vfcam_pkg::job_t               head_job,
    output logic                               pop,
    input  wire logic [vfcam_pkg::REG_W-1:0]   tile_width_q16,
    input  wire logic [vfcam_pkg::REG_W-1:0]   tile_height_q16,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [vfcam_pkg::CNT_W-1:0]        vertex_number,
    output logic [vfcam_pkg::VCOORD_W-1:0]     vert_x,
    output logic [vfcam_pkg::VCOORD_W-1:0]     vert_y,
    output logic [vfcam_pkg::VCOORD_W-1:0]     vert_z,
    output logic [vfcam_pkg::UV_W-1:0]         tex_u,
    output logic [vfcam_pkg::UV_W-1:0]         tex_v,
    output logic [vfcam_pkg::FACE_W-1:0]       face_number,
    output logic [vfcam_pkg::AO_W-1:0]         occlusion,
    output logic                               flip_diagonal,
    output logic                               last_vertex
);
    import vfcam_pkg::*;

    job_t                job_reg;
    logic                job_valid_reg;
    logic                job_valid_next;
    logic [FACES-1:0]    rem_mask_reg;
    logic [FACES-1:0]    rem_mask_next;
    logic [CORNER_W-1:0] corner_reg;
    logic [CORNER_W-1:0] corner_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [CNT_W-1:0]    out_number_reg;
    logic [VCOORD_W-1:0] out_x_reg;
    logic [VCOORD_W-1:0] out_y_reg;
    logic [VCOORD_W-1:0] out_z_reg;
    logic [UV_W-1:0]     out_u_reg;
    logic [UV_W-1:0]     out_v_reg;
    logic [FACE_W-1:0]   out_face_reg;
    logic [AO_W-1:0]     out_ao_reg;
    logic                out_flip_reg;
    logic                out_last_reg;

    logic [FACE_W-1:0]   face;
    logic [FACES-1:0]    face_bit;
    logic [FACES-1:0]    rem_after;
    logic                emit;
    logic                job_done;
    logic                clear_count;
    logic [2:0]          co;
    logic [1:0]          uv;
    logic [TILE_W:0]     u_idx;
    logic [TILE_W:0]     v_idx;
    logic [TILE_W+REG_W-1:0] u_prod;
    logic [TILE_W+REG_W-1:0] v_prod;
    logic [VCOORD_W-1:0] vert_x_next;
    logic [VCOORD_W-1:0] vert_y_next;
    logic [VCOORD_W-1:0] vert_z_next;
    logic [UV_W-1:0]     tex_u_next;
    logic [UV_W-1:0]     tex_v_next;

    // Lowest kept face still to be sent.
    always_comb begin
        face = '0;
        for (int f = FACES - 1; f >= 0; f--) begin
            if (rem_mask_reg[f]) begin
                face = FACE_W'(f);
            end
        end
        face_bit = FACES'(1) << face;
    end

    always_comb begin
        emit        = job_valid_reg && (!out_valid_reg || m_axis_tready);
        rem_after   = (corner_reg == CORNER_LAST) ? (rem_mask_reg & ~face_bit) : rem_mask_reg;
        job_done    = emit && (rem_after == '0);
        pop         = head_valid && (!job_valid_reg || job_done);
        clear_count = pop && head_job.new_chunk;

        co     = CORNER_TAB[face][corner_reg];
        uv     = UV_TAB[face][corner_reg];
        u_idx  = {1'b0, job_reg.tcol} + (TILE_W + 1)'(uv[0]);
        v_idx  = {1'b0, job_reg.trow} + (TILE_W + 1)'(uv[1]);
        u_prod = u_idx * tile_width_q16;
        v_prod = v_idx * tile_height_q16;
        tex_u_next  = u_prod[UV_W-1:0];
        tex_v_next  = v_prod[UV_W-1:0];
        vert_x_next = VCOORD_W'(job_reg.bx) + VCOORD_W'(co[0]);
        vert_y_next = VCOORD_W'(job_reg.by) + VCOORD_W'(co[1]);
        vert_z_next = VCOORD_W'(job_reg.bz) + VCOORD_W'(co[2]);

        job_valid_next = job_valid_reg;
        rem_mask_next  = rem_mask_reg;
        corner_next    = corner_reg;
        if (pop) begin
            job_valid_next = |head_job.face_mask;
            rem_mask_next  = head_job.face_mask;
            corner_next    = '0;
        end else if (emit) begin
            job_valid_next = !job_done;
            rem_mask_next  = rem_after;
            corner_next    = corner_reg + CORNER_W'(1);
        end

        // Restart numbering after the previous job's last beat is counted.
        count_next = count_reg;
        if (clear_count) begin
            count_next = '0;
        end else if (emit) begin
            count_next = count_reg + CNT_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            rem_mask_reg  <= '0;
            corner_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            rem_mask_reg  <= rem_mask_next;
            corner_reg    <= corner_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= head_job;
        end
        if (emit) begin
            out_number_reg <= count_reg;
            out_x_reg      <= vert_x_next;
            out_y_reg      <= vert_y_next;
            out_z_reg      <= vert_z_next;
            out_u_reg      <= tex_u_next;
            out_v_reg      <= tex_v_next;
            out_face_reg   <= face;
            out_ao_reg     <= job_reg.ao[face][corner_reg];
            out_flip_reg   <= job_reg.flip[face];
            out_last_reg   <= job_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign vertex_number = out_number_reg;
    assign vert_x        = out_x_reg;
    assign vert_y        = out_y_reg;
    assign vert_z        = out_z_reg;
    assign tex_u         = out_u_reg;
    assign tex_v         = out_v_reg;
    assign face_number   = out_face_reg;
    assign occlusion     = out_ao_reg;
    assign flip_diagonal = out_flip_reg;
    assign last_vertex   = out_last_reg;

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !clear_count |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("vertex count did not advance");

    a_job_has_face: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> rem_mask_reg != '0)
        else $error("active job with no face left");

    a_last_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> out_last_reg == $past(job_done))
        else $error("last vertex flag out of step with job end");

endmodule

`default_nettype wire

// ===== dv/mesher_checker.sv =====
// Vertex checker for the voxel face mesher: tracks registers, predicts vertices, compares beats.
module mesher_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    // x[4:0] y[9:5] z[14:10] opaque[15] neighbour[42:16] col[50:43] row[58:51]
    input  wire logic [63:0]                  s_axis_tdata,
    // new_chunk[0]
    input  wire logic                         s_axis_tuser,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // number[19:0] x[25:20] y[31:26] z[37:32] u[62:38] v[87:63]
    // face[90:88] occlusion[92:91] flip[93]
    input  wire logic [95:0]                  m_axis_tdata,
    input  wire logic                         m_axis_tlast,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic                         pready,
    input  wire logic [vfcam_pkg::ADDR_W-1:0] paddr,
    input  wire logic [vfcam_pkg::DATA_W-1:0] pwdata,
    output int                                errors,
    output int                                vertices_due
);
    import vfcam_pkg::*;

    localparam logic [REG_W-1:0] UNITY_Q16 = 17'h10000;

    typedef struct packed {
        logic [CNT_W-1:0]    number;
        logic [VCOORD_W-1:0] x;
        logic [VCOORD_W-1:0] y;
        logic [VCOORD_W-1:0] z;
        logic [UV_W-1:0]     u;
        logic [UV_W-1:0]     v;
        logic [FACE_W-1:0]   face;
        logic [AO_W-1:0]     occl;
        logic                flip;
        logic                last;
    } vertex_t;

    vertex_t          pending_vertices [$];
    logic [CNT_W-1:0] vertex_count = '0;
    logic [REG_W-1:0] tile_width   = UNITY_Q16;
    logic [REG_W-1:0] tile_height  = UNITY_Q16;
    int               fails        = 0;

    assign errors = fails;

    // {x,y,z} offset of each corner, corner 0 in the top bits
    function automatic logic [2:0] corner_xyz(input int f, input int c);
        logic [11:0] quad;
        case (f)
            0: quad = 12'b110_111_101_100;
            1: quad = 12'b011_010_000_001;
            2: quad = 12'b011_111_110_010;
            3: quad = 12'b000_100_101_001;
            4: quad = 12'b011_001_101_111;
            default: quad = 12'b110_100_000_010;
        endcase
        return quad[11 - 3 * c -: 3];
    endfunction

    // {u,v} local texture corner
    function automatic logic [1:0] corner_uv(input int f, input int c);
        logic [7:0] quad;
        quad = (f < 4) ? 8'b00_10_11_01 : 8'b00_01_11_10;
        return quad[7 - 2 * c -: 2];
    endfunction

    function automatic int normal_of(input int f, input int a);
        return (a == f / 2) ? ((f % 2 == 1) ? -1 : 1) : 0;
    endfunction

    function automatic logic cell_set(input logic [NB_W-1:0] nb, input int dx, input int dy,
                                      input int dz);
        return nb[(dz + 1) * 9 + (dy + 1) * 3 + (dx + 1)];
    endfunction

    function automatic logic [AO_W-1:0] vertex_ao(input logic [NB_W-1:0] nb, input int f,
                                                  input int c);
        int         t0;
        int         t1;
        int         a;
        int         s1 [3];
        int         s2 [3];
        int         dg [3];
        logic [2:0] ofs;
        logic       side1;
        logic       side2;
        logic       diag;
        t0  = (f / 2 == 0) ? 1 : 0;
        t1  = (f / 2 == 2) ? 1 : 2;
        ofs = corner_xyz(f, c);
        for (a = 0; a < 3; a++) begin
            s1[a] = normal_of(f, a);
            s2[a] = s1[a];
            dg[a] = s1[a];
        end
        s1[t0] = s1[t0] + (ofs[2 - t0] ? 1 : -1);
        s2[t1] = s2[t1] + (ofs[2 - t1] ? 1 : -1);
        dg[t0] = s1[t0];
        dg[t1] = s2[t1];
        side1 = cell_set(nb, s1[0], s1[1], s1[2]);
        side2 = cell_set(nb, s2[0], s2[1], s2[2]);
        diag  = cell_set(nb, dg[0], dg[1], dg[2]);
        if (side1 && side2) begin
            return '0;
        end
        return AO_W'(3 - int'(side1) - int'(side2) - int'(diag));
    endfunction

    task automatic mesh_block(input logic [63:0] d, input logic fresh);
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [COORD_W-1:0] bz;
        logic               solid;
        logic [NB_W-1:0]    nb;
        logic [TILE_W-1:0]  col;
        logic [TILE_W-1:0]  row;
        logic [FACES-1:0]   kept;
        logic [AO_W-1:0]    ao [CORNERS];
        logic               flip;
        logic [2:0]         ofs;
        logic [1:0]         luv;
        vertex_t            vx;
        int                 f;
        int                 c;
        int                 last_face;
        int                 tu;
        int                 tv;
        bx    = d[4:0];
        by    = d[9:5];
        bz    = d[14:10];
        solid = d[15];
        nb    = d[42:16];
        col   = d[50:43];
        row   = d[58:51];
        if (fresh) begin
            vertex_count = '0;
        end
        if (!solid) begin
            return;
        end
        last_face = -1;
        for (f = 0; f < FACES; f++) begin
            kept[f] = !cell_set(nb, normal_of(f, 0), normal_of(f, 1), normal_of(f, 2));
            if (kept[f]) begin
                last_face = f;
            end
        end
        for (f = 0; f < FACES; f++) begin
            if (!kept[f]) begin
                continue;
            end
            for (c = 0; c < CORNERS; c++) begin
                ao[c] = vertex_ao(nb, f, c);
            end
            flip = (int'(ao[0]) + int'(ao[2])) < (int'(ao[1]) + int'(ao[3]));
            for (c = 0; c < CORNERS; c++) begin
                ofs       = corner_xyz(f, c);
                luv       = corner_uv(f, c);
                tu        = int'(col) + int'(luv[1]);
                tv        = int'(row) + int'(luv[0]);
                vx.number = vertex_count;
                vx.x      = VCOORD_W'(bx) + ofs[2];
                vx.y      = VCOORD_W'(by) + ofs[1];
                vx.z      = VCOORD_W'(bz) + ofs[0];
                vx.u      = UV_W'(longint'(tu) * longint'(tile_width));
                vx.v      = UV_W'(longint'(tv) * longint'(tile_height));
                vx.face   = FACE_W'(f);
                vx.occl   = ao[c];
                vx.flip   = flip;
                vx.last   = (f == last_face) && (c == CORNERS - 1);
                pending_vertices = {pending_vertices, vx};
                vertex_count = vertex_count + 1'b1;
            end
        end
    endtask

    task automatic mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        fails++;
    endtask

    task automatic check_vertex(input logic [95:0] d, input logic tlast);
        vertex_t want;
        if (pending_vertices.size() == 0) begin
            $display("%0t: vertex beat expected none got %h", $time, d);
            fails++;
            return;
        end
        want = pending_vertices.pop_front();
        if (d[19:0] !== want.number) mismatch("vertex_number", 32'(want.number), 32'(d[19:0]));
        if (d[25:20] !== want.x) mismatch("vert_x", 32'(want.x), 32'(d[25:20]));
        if (d[31:26] !== want.y) mismatch("vert_y", 32'(want.y), 32'(d[31:26]));
        if (d[37:32] !== want.z) mismatch("vert_z", 32'(want.z), 32'(d[37:32]));
        if (d[62:38] !== want.u) mismatch("tex_u", 32'(want.u), 32'(d[62:38]));
        if (d[87:63] !== want.v) mismatch("tex_v", 32'(want.v), 32'(d[87:63]));
        if (d[90:88] !== want.face) mismatch("face_number", 32'(want.face), 32'(d[90:88]));
        if (d[92:91] !== want.occl) mismatch("occlusion", 32'(want.occl), 32'(d[92:91]));
        if (d[93] !== want.flip) mismatch("flip_diagonal", 32'(want.flip), 32'(d[93]));
        if (tlast !== want.last) mismatch("last_vertex", 32'(want.last), 32'(tlast));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count = '0;
            tile_width   = UNITY_Q16;
            tile_height  = UNITY_Q16;
            pending_vertices.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_vertex(m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                mesh_block(s_axis_tdata, s_axis_tuser);
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_TILE_WIDTH) begin
                    tile_width = pwdata[REG_W-1:0];
                end else begin
                    tile_height = pwdata[REG_W-1:0];
                end
            end
        end
        vertices_due <= pending_vertices.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the voxel face mesher: clock, reset, block and register stimulus, verdict.
module tb;
    import vfcam_pkg::*;

    localparam int WATCHDOG     = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_BLOCKS = 42;

    typedef struct packed {
        logic [TILE_W-1:0]  row;
        logic [TILE_W-1:0]  col;
        logic [NB_W-1:0]    nb;
        logic               solid;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } block_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [63:0]        s_axis_tdata  = '0;
    logic               s_axis_tuser  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [95:0]        m_axis_tdata;
    logic               m_axis_tlast;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [DATA_W-1:0]  pwdata        = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    int                 errors;
    int                 vertices_due;
    int                 gap_pct       = 0;
    int                 stall_pct     = 0;
    int                 quiet         = 0;

    voxel_face_cull_ao_mesher uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mesher_checker vertex_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .errors        (errors),
        .vertices_due  (vertices_due)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic block_t block_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                        input logic [COORD_W-1:0] z, input logic solid,
                                        input logic [NB_W-1:0] nb, input logic [TILE_W-1:0] col,
                                        input logic [TILE_W-1:0] row);
        block_t b;
        b.x     = x;
        b.y     = y;
        b.z     = z;
        b.solid = solid;
        b.nb    = nb;
        b.col   = col;
        b.row   = row;
        return b;
    endfunction

    // neighbourhood cells with exactly k non-zero offsets
    function automatic logic [NB_W-1:0] cells_with(input int k);
        logic [NB_W-1:0] m;
        int              dx;
        int              dy;
        int              dz;
        m = '0;
        for (dz = -1; dz <= 1; dz++) begin
            for (dy = -1; dy <= 1; dy++) begin
                for (dx = -1; dx <= 1; dx++) begin
                    if ((dx != 0) + (dy != 0) + (dz != 0) == k) begin
                        m[(dz + 1) * 9 + (dy + 1) * 3 + (dx + 1)] = 1'b1;
                    end
                end
            end
        end
        return m;
    endfunction

    function automatic block_t random_block();
        block_t b;
        b.x     = COORD_W'($urandom);
        b.y     = COORD_W'($urandom);
        b.z     = COORD_W'($urandom);
        b.solid = ($urandom_range(0, 99) < 85);
        b.col   = TILE_W'($urandom);
        b.row   = TILE_W'($urandom);
        case ($urandom_range(0, 3))
            0: b.nb = NB_W'($urandom & $urandom & $urandom);
            1: b.nb = NB_W'($urandom);
            2: b.nb = NB_W'($urandom | $urandom);
            default: b.nb = NB_W'($urandom | $urandom | $urandom);
        endcase
        return b;
    endfunction

    task automatic send_block(input logic fresh, input block_t b);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fresh;
        s_axis_tdata  <= {5'b0, b};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [REG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (vertices_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int phase;
        int f;
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_block(1'b1, block_at(0, 0, 0, 1'b1, '0, 0, 0));
        send_block(1'b0, block_at(31, 31, 31, 1'b1, '0, 255, 255));
        send_block(1'b0, block_at(7, 8, 9, 1'b1, '1, 3, 4));
        send_block(1'b1, block_at(7, 8, 9, 1'b1, '1, 3, 4));
        send_block(1'b0, block_at(1, 2, 3, 1'b0, '0, 5, 6));
        send_block(1'b1, block_at(1, 2, 3, 1'b0, '0, 5, 6));
        send_block(1'b0, block_at(10, 20, 30, 1'b1, ~cells_with(1), 12, 34));
        send_block(1'b0, block_at(30, 20, 10, 1'b1, cells_with(3), 56, 78));
        send_block(1'b0, block_at(15, 16, 17, 1'b1, cells_with(2), 90, 12));
        for (f = 0; f < FACES; f++) begin
            k = 13 + ((f % 2 == 1) ? -1 : 1) * ((f / 2 == 0) ? 1 : (f / 2 == 1) ? 3 : 9);
            send_block(f == 3, block_at(COORD_W'($urandom), COORD_W'($urandom),
                                        COORD_W'($urandom), 1'b1, ~(NB_W'(1) << k),
                                        TILE_W'($urandom), TILE_W'($urandom)));
        end
        for (k = 0; k < 5; k++) begin
            send_block(1'b0, block_at(COORD_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom), 1'b1,
                                      NB_W'($urandom) & ~cells_with(1),
                                      TILE_W'($urandom), TILE_W'($urandom)));
        end

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    write_reg(REG_TILE_WIDTH, 17'd1);
                    write_reg(REG_TILE_HEIGHT, 17'd1);
                end
                1: begin
                    write_reg(REG_TILE_WIDTH, 17'h1FFFF);
                    write_reg(REG_TILE_HEIGHT, 17'h1FFFF);
                end
                2: begin
                    write_reg(REG_TILE_WIDTH, 17'd0);
                    write_reg(REG_TILE_HEIGHT, 17'h10000);
                end
                3: begin
                    write_reg(REG_TILE_WIDTH, 17'h10000);
                    write_reg(REG_TILE_HEIGHT, 17'd0);
                end
                4, 5: begin
                    write_reg(REG_TILE_WIDTH, REG_W'($urandom_range(1, 65536)));
                    write_reg(REG_TILE_HEIGHT, REG_W'($urandom_range(1, 65536)));
                end
                default: begin
                    write_reg(REG_TILE_WIDTH, REG_W'($urandom));
                    write_reg(REG_TILE_HEIGHT, REG_W'($urandom));
                end
            endcase
            case (phase % 4)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct   = 51;
                    stall_pct = 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct = 51;
                end
                default: begin
                    gap_pct   = 31;
                    stall_pct = 31;
                end
            endcase
            repeat (PHASE_BLOCKS) send_block($urandom_range(0, 99) < 8, random_block());
        end
        drain();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/vfcam_pkg.sv
rtl/vfcam_front.sv
rtl/vfcam_queue.sv
rtl/vfcam_back.sv
rtl/voxel_face_cull_ao_mesher.sv
dv/mesher_checker.sv
dv/tb.sv
